FILE: rtl/evs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// evs_pkg
// Shared types and constants for the epoch-stamped visited set.
// ----------------------------------------------------------------------------
package evs_pkg;

	// field widths
	localparam int KIND_W  = 2;
	localparam int INDEX_W = 10;
	localparam int COUNT_W = 11;
	localparam int EPOCH_W = 32;

	// defaults
	localparam int MAX_OBJECTS_DEF = 1024;
	localparam logic [COUNT_W-1:0] COUNT_RESET = 11'd1024;
	localparam logic [EPOCH_W-1:0] EPOCH_LAST  = 32'hFFFF_FFFF;
	localparam logic [EPOCH_W-1:0] EPOCH_FIRST = 32'h0000_0001;

	// operation codes
	localparam logic [KIND_W-1:0] KIND_PASS  = 2'd0;
	localparam logic [KIND_W-1:0] KIND_VISIT = 2'd1;
	localparam logic [KIND_W-1:0] KIND_QUERY = 2'd2;

	typedef struct packed {
		logic [KIND_W-1:0]  kind;
		logic [INDEX_W-1:0] index;
	} evs_req_t;

	typedef struct packed {
		logic flag;
		logic out_of_range;
	} evs_rsp_t;

endpackage

FILE: rtl/evs_stamp_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// evs_stamp_ram
// Stamp memory: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module evs_stamp_ram
	import evs_pkg::*;
#(
	parameter int DEPTH = MAX_OBJECTS_DEF,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic               clk,
	input  logic               we,
	input  logic [AW-1:0]      waddr,
	input  logic [EPOCH_W-1:0] wdata,
	input  logic               re,
	input  logic [AW-1:0]      raddr,
	output logic [EPOCH_W-1:0] rdata
);

	logic [EPOCH_W-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read port, registered read data
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: rtl/evs_clear_ctl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// evs_clear_ctl
// Clearing sweep: walks every stamp address once, one entry per cycle.
// Runs after reset and whenever start is pulsed.
// ----------------------------------------------------------------------------
module evs_clear_ctl
	import evs_pkg::*;
#(
	parameter int DEPTH = MAX_OBJECTS_DEF,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	output logic [AW-1:0] addr
);

	localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

	logic          busy_q;
	logic [AW-1:0] addr_q;

	// sweep counter; a new start restarts from entry zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b1;
			addr_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			addr_q <= '0;
		end else if (busy_q) begin
			if (addr_q == LAST_ADDR) begin
				busy_q <= 1'b0;
				addr_q <= '0;
			end else begin
				addr_q <= addr_q + AW'(1);
			end
		end
	end

	assign busy = busy_q;
	assign addr = addr_q;

endmodule

FILE: rtl/epoch_visited_set_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// epoch_visited_set_unit
// Visited-marker set over numbered objects, cleared in one step by advancing
// an epoch. Stamps live in a synchronous RAM; visits read, compare and write
// back with forwarding between neighboring transfers.
//
//   channel | signals                    | direction | payload
//   --------+----------------------------+-----------+-------------------
//   req     | req_valid/req_stall        | in        | evs_req_t
//   rsp     | rsp_valid/rsp_stall        | out       | evs_rsp_t
//   cfg     | cfg_we/cfg_wdata           | in        | object_count, 11b
//
// One item per cycle while no sweep, cfg write or stalled response holds req;
// an accepted item passes through stage 1 and then the response register.
// A new pass taken with the epoch at its last value holds the request side
// while it waits in stage 1 and then while the stamp RAM is swept to zero.
// After reset and after each cfg write, a sweep over every stamp entry runs
// with the request side stalled; cfg writes are taken throughout.
// A stalled response holds the pipeline stage behind it, and with it req.
// ----------------------------------------------------------------------------
module epoch_visited_set_unit
	import evs_pkg::*;
#(
	parameter int MAX_OBJECTS = MAX_OBJECTS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_stall,
	input  evs_req_t           req_data,
	output logic               rsp_valid,
	input  logic               rsp_stall,
	output evs_rsp_t           rsp_data,
	input  logic               cfg_we,
	input  logic [COUNT_W-1:0] cfg_wdata
);

	localparam int AW = $clog2(MAX_OBJECTS);
	localparam logic [COUNT_W-1:0] RESET_COUNT =
		(32'(COUNT_RESET) > 32'(MAX_OBJECTS)) ? COUNT_W'(MAX_OBJECTS) : COUNT_RESET;

	logic [COUNT_W-1:0] count_q;
	logic [EPOCH_W-1:0] epoch_q;

	logic               clr_busy;
	logic [AW-1:0]      clr_addr;
	logic               clr_start;

	logic               s1_v;
	logic [KIND_W-1:0]  s1_kind;
	logic [AW-1:0]      s1_addr;
	logic               s1_oor;
	logic               s1_fwd;

	logic               rsp_valid_q;
	evs_rsp_t           rsp_q;

	logic               accept;
	logic               s1_adv;
	logic               s1_hold_roll;
	logic               s1_wr;
	logic               s1_hit;
	logic               s1_flag;
	logic               roll;
	logic [EPOCH_W-1:0] stamp;
	logic [EPOCH_W-1:0] rdata;
	logic [AW-1:0]      req_addr;
	logic               req_oor;

	logic               ram_we;
	logic [AW-1:0]      ram_waddr;
	logic [EPOCH_W-1:0] ram_wdata;

	// handshake
	assign s1_adv       = s1_v && (!rsp_valid_q || !rsp_stall);
	assign roll         = (s1_kind == KIND_PASS) && (epoch_q == EPOCH_LAST);
	assign s1_hold_roll = s1_v && roll;
	assign req_stall    = clr_busy || cfg_we || s1_hold_roll || (s1_v && !s1_adv);
	assign accept       = req_valid && !req_stall;

	// request decode
	assign req_addr = AW'(req_data.index);
	assign req_oor  = ({1'b0, req_data.index} >= count_q);

	// compare against epoch, taking the stamp just written if it is ours
	assign stamp  = s1_fwd ? epoch_q : rdata;
	assign s1_hit = (stamp == epoch_q);
	assign s1_wr  = s1_adv && (s1_kind == KIND_VISIT) && !s1_oor && !s1_hit;

	always_comb begin
		case (s1_kind)
			KIND_VISIT: s1_flag = !s1_oor && !s1_hit;
			KIND_QUERY: s1_flag = !s1_oor && s1_hit;
			default:    s1_flag = 1'b0;
		endcase
	end

	// sweep starts on a count write or on epoch rollover
	assign clr_start = cfg_we || (s1_adv && roll);

	// RAM write port: sweep or visit
	assign ram_we    = clr_busy || s1_wr;
	assign ram_waddr = clr_busy ? clr_addr : s1_addr;
	assign ram_wdata = clr_busy ? '0 : epoch_q;

	evs_stamp_ram #(
		.DEPTH (MAX_OBJECTS)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (accept),
		.raddr (req_addr),
		.rdata (rdata)
	);

	evs_clear_ctl #(
		.DEPTH (MAX_OBJECTS)
	) u_clr (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (clr_start),
		.busy   (clr_busy),
		.addr   (clr_addr)
	);

	// count and epoch
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= RESET_COUNT;
			epoch_q <= '0;
		end else if (cfg_we) begin
			if (32'(cfg_wdata) > 32'(MAX_OBJECTS)) begin
				count_q <= COUNT_W'(MAX_OBJECTS);
			end else begin
				count_q <= cfg_wdata;
			end
			epoch_q <= '0;
		end else if (s1_adv && (s1_kind == KIND_PASS)) begin
			epoch_q <= roll ? EPOCH_FIRST : epoch_q + EPOCH_W'(1);
		end
	end

	// stage 1 valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_v <= 1'b0;
		end else if (accept) begin
			s1_v <= 1'b1;
		end else if (s1_adv) begin
			s1_v <= 1'b0;
		end
	end

	// stage 1 payload, forward flag when the item ahead writes our entry
	always_ff @(posedge clk) begin
		if (accept) begin
			s1_kind <= req_data.kind;
			s1_addr <= req_addr;
			s1_oor  <= req_oor;
			s1_fwd  <= s1_wr && (s1_addr == req_addr);
		end
	end

	// response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (s1_adv) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			rsp_q.flag         <= s1_flag;
			rsp_q.out_of_range <= s1_oor && ((s1_kind == KIND_VISIT) ||
				(s1_kind == KIND_QUERY));
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp_data  = rsp_q;

	// checks
	a_no_wr_in_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		clr_busy |-> !s1_wr)
		else $error("visit write during clearing sweep");

	a_roll_sweeps: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_adv && roll && !cfg_we) |=> (clr_busy && (epoch_q == EPOCH_FIRST)))
		else $error("rollover did not start sweep with epoch one");

	a_no_item_in_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		clr_busy |-> !s1_v)
		else $error("item in flight during clearing sweep");

	a_oor_no_flag: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> !(rsp_data.flag && rsp_data.out_of_range))
		else $error("out of range result carries a flag");

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for epoch_visited_set_unit. A short directed table of
// passes, visits, queries and object-count writes is followed by randomized
// traffic under a series of count settings. Both sides insert random gaps,
// except during one quiet phase. A typed table row checks its own result;
// others against a model of the stamp store and epoch kept in the bench.
// ----------------------------------------------------------------------------
module tb_top;
	import evs_pkg::*;

	localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;
	localparam int IDLE_PCT    = 29;
	localparam int PHASE_ITEMS = 195;
	localparam int NUM_PHASES  = 9;
	localparam int QUIET_PHASE = 4;

	// response shorthands for the directed table
	localparam evs_rsp_t RSP_SET   = '{flag: 1'b1, out_of_range: 1'b0};
	localparam evs_rsp_t RSP_CLEAR = '{flag: 1'b0, out_of_range: 1'b0};
	localparam evs_rsp_t RSP_OOR   = '{flag: 1'b0, out_of_range: 1'b1};

	typedef struct packed {
		logic               is_cfg;
		logic [COUNT_W-1:0] count;
		evs_req_t           req;
		logic               typed;
		evs_rsp_t           want;
	} dir_row_t;

	// directed table: count writes and transfers, typed results where obvious
	dir_row_t directed_rows [26] = '{
		// after reset: epoch and stamps are zero, so everything reads visited
		'{1'b0, 11'd0, '{KIND_QUERY, 10'd0},    1'b1, RSP_SET},
		'{1'b0, 11'd0, '{KIND_VISIT, 10'd1023}, 1'b1, RSP_CLEAR},
		'{1'b0, 11'd0, '{KIND_SPARE, 10'd5},    1'b1, RSP_CLEAR},
		// first pass, then mark and re-mark
		'{1'b0, 11'd0, '{KIND_PASS,  10'd0},    1'b1, RSP_CLEAR},
		'{1'b0, 11'd0, '{KIND_QUERY, 10'd0},    1'b1, RSP_CLEAR},
		'{1'b0, 11'd0, '{KIND_VISIT, 10'd0},    1'b1, RSP_SET},
		'{1'b0, 11'd0, '{KIND_VISIT, 10'd0},    1'b1, RSP_CLEAR},
		'{1'b0, 11'd0, '{KIND_QUERY, 10'd0},    1'b1, RSP_SET},
		'{1'b0, 11'd0, '{KIND_VISIT, 10'd1023}, 1'b0, RSP_CLEAR},
		'{1'b0, 11'd0, '{KIND_QUERY, 10'd682},  1'b0, RSP_CLEAR},
		'{1'b0, 11'd0, '{KIND_VISIT, 10'd341},  1'b0, RSP_CLEAR},
		'{1'b0, 11'd0, '{KIND_PASS,  10'd1023}, 1'b1, RSP_CLEAR},
		'{1'b0, 11'd0, '{KIND_QUERY, 10'd1023}, 1'b0, RSP_CLEAR},
		// zero count: every visit and query is out of range
		'{1'b1, 11'd0, '{KIND_PASS,  10'd0},    1'b0, RSP_CLEAR},
		'{1'b0, 11'd0, '{KIND_VISIT, 10'd0},    1'b1, RSP_OOR},
		'{1'b0, 11'd0, '{KIND_QUERY, 10'd1023}, 1'b1, RSP_OOR},
		'{1'b0, 11'd0, '{KIND_PASS,  10'd0},    1'b1, RSP_CLEAR},
		// count above capacity saturates; epoch back at zero
		'{1'b1, 11'd2047, '{KIND_PASS, 10'd0},  1'b0, RSP_CLEAR},
		'{1'b0, 11'd0, '{KIND_QUERY, 10'd1023}, 1'b1, RSP_SET},
		// single object
		'{1'b1, 11'd1, '{KIND_PASS,  10'd0},    1'b0, RSP_CLEAR},
		'{1'b0, 11'd0, '{KIND_VISIT, 10'd1},    1'b1, RSP_OOR},
		'{1'b0, 11'd0, '{KIND_VISIT, 10'd0},    1'b1, RSP_CLEAR},
		'{1'b0, 11'd0, '{KIND_PASS,  10'd0},    1'b1, RSP_CLEAR},
		'{1'b0, 11'd0, '{KIND_VISIT, 10'd0},    1'b1, RSP_SET},
		// back to full capacity
		'{1'b1, 11'd1024, '{KIND_PASS, 10'd0},  1'b0, RSP_CLEAR},
		'{1'b0, 11'd0, '{KIND_QUERY, 10'd512},  1'b1, RSP_SET}
	};

	logic               clk       = 1'b0;
	logic               arst_n;
	logic               req_valid;
	logic               req_stall;
	evs_req_t           req_data;
	logic               rsp_valid;
	logic               rsp_stall = 1'b0;
	evs_rsp_t           rsp_data;
	logic               cfg_we;
	logic [COUNT_W-1:0] cfg_wdata;

	// model of the set, updated on accepted transfers and count writes
	logic [EPOCH_W-1:0] stamps [MAX_OBJECTS_DEF];
	logic [EPOCH_W-1:0] epoch_now;
	logic [COUNT_W-1:0] count_now;
	evs_rsp_t           marks_due [$];
	int                 fail_count = 0;
	logic               no_idle    = 1'b0;
	logic               cur_typed  = 1'b0;
	evs_rsp_t           cur_want   = '0;

	epoch_visited_set_unit uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req_data  (req_data),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp_data  (rsp_data),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic void wipe_stamps();
		for (int i = 0; i < MAX_OBJECTS_DEF; i++)
			stamps[i] = '0;
	endfunction

	// count write: saturate, clear the store, restart the epoch
	function automatic void load_object_count(logic [COUNT_W-1:0] value);
		count_now = (value > MAX_OBJECTS_DEF) ? COUNT_W'(MAX_OBJECTS_DEF) : value;
		wipe_stamps();
		epoch_now = '0;
	endfunction

	// expected response for one transfer; updates stamps and epoch
	function automatic evs_rsp_t mark_result(evs_req_t item);
		evs_rsp_t res;
		res = RSP_CLEAR;
		case (item.kind)
			KIND_PASS: begin
				// rollover: clear everything before stepping past the last epoch
				if (epoch_now == EPOCH_LAST) begin
					wipe_stamps();
					epoch_now = '0;
				end
				epoch_now = epoch_now + 1'b1;
			end
			KIND_VISIT, KIND_QUERY: begin
				if (item.index >= count_now) begin
					res.out_of_range = 1'b1;
				end else if (item.kind == KIND_VISIT) begin
					if (stamps[item.index] != epoch_now) begin
						stamps[item.index] = epoch_now;
						res.flag = 1'b1;
					end
				end else begin
					res.flag = (stamps[item.index] == epoch_now);
				end
			end
			default: ;
		endcase
		return res;
	endfunction

	// response side back-pressure
	always @(negedge clk) rsp_stall = !no_idle && ($urandom_range(0, 99) < IDLE_PCT);

	// scoreboard: predict on request transfer, compare on response transfer
	always @(posedge clk) begin : scoreboard
		evs_rsp_t due;
		if (arst_n) begin
			if (cfg_we)
				load_object_count(cfg_wdata);
			if (req_valid && !req_stall) begin
				due = mark_result(req_data);
				if (cur_typed)
					due = cur_want;
				marks_due.push_back(due);
			end
			if (rsp_valid && !rsp_stall) begin
				if (marks_due.size() == 0) begin
					$error("unexpected response: flag=%0b out_of_range=%0b",
						rsp_data.flag, rsp_data.out_of_range);
					fail_count++;
				end else begin
					due = marks_due.pop_front();
					if (rsp_data.flag !== due.flag) begin
						$error("flag: expected %0b, actual %0b", due.flag, rsp_data.flag);
						fail_count++;
					end
					if (rsp_data.out_of_range !== due.out_of_range) begin
						$error("out_of_range: expected %0b, actual %0b",
							due.out_of_range, rsp_data.out_of_range);
						fail_count++;
					end
				end
			end
		end
	end

	// one request transfer, with random idle cycles ahead of it
	task automatic send_item(evs_req_t item, logic typed, evs_rsp_t want);
		while (!no_idle && ($urandom_range(0, 99) < IDLE_PCT)) begin
			req_valid = 1'b0;
			@(negedge clk);
		end
		req_valid = 1'b1;
		req_data  = item;
		cur_typed = typed;
		cur_want  = want;
		do @(posedge clk); while (req_stall);
		@(negedge clk);
	endtask

	// count write once the block has drained
	task automatic write_count(logic [COUNT_W-1:0] value);
		req_valid = 1'b0;
		while (marks_due.size() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
		cfg_we    = 1'b1;
		cfg_wdata = value;
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	initial begin : stimulus
		logic [COUNT_W-1:0] phase_counts [NUM_PHASES];
		evs_req_t           item;
		int                 roll;
		int                 span;
		arst_n    = 1'b0;
		req_valid = 1'b0;
		req_data  = '0;
		cfg_we    = 1'b0;
		cfg_wdata = '0;
		load_object_count(COUNT_RESET);
		phase_counts = '{11'd5, 11'd2047, 11'd1, 11'd0, 11'd1023, 11'd1025, 11'd64, 11'd2,
			11'd0};
		phase_counts[NUM_PHASES-1] = COUNT_W'($urandom_range(0, 2047));
		repeat (2) @(negedge clk);
		arst_n = 1'b1;

		foreach (directed_rows[i]) begin
			if (directed_rows[i].is_cfg)
				write_count(directed_rows[i].count);
			else
				send_item(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].want);
		end

		// random traffic, one count setting per phase
		for (int p = 0; p < NUM_PHASES; p++) begin
			write_count(phase_counts[p]);
			no_idle = (p == QUIET_PHASE);
			span = int'(count_now);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				roll = $urandom_range(0, 99);
				if (roll < 10)
					item.kind = KIND_PASS;
				else if (roll < 55)
					item.kind = KIND_VISIT;
				else if (roll < 96)
					item.kind = KIND_QUERY;
				else
					item.kind = KIND_SPARE;
				// mostly a small hot set so marks get revisited within a pass
				roll = $urandom_range(0, 99);
				if (span == 0 || roll >= 85)
					item.index = INDEX_W'($urandom_range(0, 1023));
				else if (roll < 60)
					item.index = INDEX_W'($urandom_range(0, ((span < 16) ? span : 16) - 1));
				else
					item.index = INDEX_W'($urandom_range(0, span - 1));
				send_item(item, 1'b0, RSP_CLEAR);
			end
			no_idle = 1'b0;
		end

		// drain
		req_valid = 1'b0;
		while (marks_due.size() != 0) @(negedge clk);
		repeat (8) @(negedge clk);
		if (fail_count == 0)
			$display("epoch_visited_set_unit verification clean");
		else
			$display("epoch_visited_set_unit verification failed");
		$finish;
	end

	// watchdog
	initial begin
		#500000;
		$display("epoch_visited_set_unit verification failed");
		$finish;
	end

endmodule
